>>> design/lds_pkg.sv
package lds_pkg;

    localparam int DEF_MAX_SLICES    = 256;
    localparam int DEF_LOG_FRAC_BITS = 16;

    localparam int DIST_W     = 32;
    localparam int POS_W      = 5;
    localparam int SLICE_W    = 8;
    localparam int CNT_REG_W  = 9;
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] CFG_PROJ_SET = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_NEAR     = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FAR      = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_COUNT    = 2'd3;

    localparam logic [DIST_W-1:0]    RST_NEAR  = 32'd65536;
    localparam logic [DIST_W-1:0]    RST_FAR   = 32'd65536000;
    localparam logic [CNT_REG_W-1:0] RST_COUNT = 9'd16;

    // log lanes carried side by side: view distance, near plane, far plane
    localparam int LANES  = 3;
    localparam int LANE_D = 0;
    localparam int LANE_N = 1;
    localparam int LANE_F = 2;

    // how the final slice is chosen
    localparam logic [1:0] SEL_ZERO = 2'd0;
    localparam logic [1:0] SEL_LAST = 2'd1;
    localparam logic [1:0] SEL_CALC = 2'd2;

    typedef struct packed {
        logic       vld;
        logic [1:0] sel;
    } t_ctl;

    typedef struct packed {
        logic [POS_W-1:0]  pos;
        logic [DIST_W-1:0] man;
    } t_norm;

    // leading-one position and mantissa left-justified as q1.31
    function automatic t_norm norm_q131(input logic [DIST_W-1:0] x);
        t_norm             r;
        logic [DIST_W-1:0] s;
        logic [POS_W-1:0]  lz;
        s  = x;
        lz = '0;
        if (s[31:16] == 16'd0) begin
            s     = s << 16;
            lz[4] = 1'b1;
        end
        if (s[31:24] == 8'd0) begin
            s     = s << 8;
            lz[3] = 1'b1;
        end
        if (s[31:28] == 4'd0) begin
            s     = s << 4;
            lz[2] = 1'b1;
        end
        if (s[31:30] == 2'd0) begin
            s     = s << 2;
            lz[1] = 1'b1;
        end
        if (s[31] == 1'b0) begin
            s     = s << 1;
            lz[0] = 1'b1;
        end
        r.man = s;
        r.pos = 5'd31 - lz;
        return r;
    endfunction

endpackage

>>> design/log_depth_slice_select.sv
// logarithmic depth slice selector
// the configuration port writes projection_set, near and far planes and the
// slice count by register index; writes land at once, and the user makes
// them only while no item is in flight; the block does not enforce it. view
// distances enter on i_in_valid / o_in_stall and the slice index leaves on
// o_out_valid / i_out_stall. one item is taken every cycle while o_in_stall
// is low; the pipeline is a row of squaring cells, each doing one 32x32
// product per log lane, followed by one cell per quotient bit.
// all stages move together; the output register is backed by a one-entry
// skid, so an item still enters while a result waits to be taken. a stall on
// the output fills the skid, and only then is o_in_stall raised, until the
// skid drains.
// reset (synchronous, active low) drops every item in flight, clears
// projection_set and loads near 1.0, far 1000.0 and a count of 16.
module log_depth_slice_select import lds_pkg::*; #(
    parameter int MAX_SLICES    = DEF_MAX_SLICES,
    parameter int LOG_FRAC_BITS = DEF_LOG_FRAC_BITS
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic [DIST_W-1:0]     i_view_distance,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [SLICE_W-1:0]    o_slice_index
);

    localparam int LW = POS_W + LOG_FRAC_BITS;
    localparam int QW = $clog2(MAX_SLICES + 1);
    localparam int DW = LW + QW;

    // configuration
    logic                 r_proj_set;
    logic [DIST_W-1:0]    r_near;
    logic [DIST_W-1:0]    r_far;
    logic [CNT_REG_W-1:0] r_slice_count;
    logic [QW-1:0]        cnt_c;
    logic [QW-1:0]        cnt_m1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_proj_set    <= 1'b0;
            r_near        <= RST_NEAR;
            r_far         <= RST_FAR;
            r_slice_count <= RST_COUNT;
        end else if (i_cfg_we) begin
            unique case (i_cfg_addr)
                CFG_PROJ_SET: r_proj_set    <= i_cfg_data[0];
                CFG_NEAR:     r_near        <= i_cfg_data;
                CFG_FAR:      r_far         <= i_cfg_data;
                CFG_COUNT:    r_slice_count <= i_cfg_data[CNT_REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_slice_count == '0) begin
            cnt_c = QW'(1);
        end else if (32'(r_slice_count) > 32'(MAX_SLICES)) begin
            cnt_c = QW'(MAX_SLICES);
        end else begin
            cnt_c = QW'(r_slice_count);
        end
    end

    assign cnt_m1 = cnt_c - QW'(1);

    // pipeline enable: every stage holds while the skid is occupied
    logic en;
    logic r_skid_vld;

    assign en         = !r_skid_vld;
    assign o_in_stall = r_skid_vld;

    // input stage: case decision and normalization of the three lanes
    t_ctl                         n_in_ctl, r_in_ctl;
    logic [LANES-1:0][DIST_W-1:0] n_in_man, r_in_man;
    logic [LANES-1:0][LW-1:0]     n_in_lg, r_in_lg;
    t_norm                        nrm_d, nrm_n, nrm_f;

    assign nrm_d = norm_q131(i_view_distance);
    assign nrm_n = norm_q131(r_near);
    assign nrm_f = norm_q131(r_far);

    always_comb begin
        n_in_ctl.vld = i_in_valid;
        if (!r_proj_set || r_near == '0 || r_far <= r_near || i_view_distance <= r_near) begin
            n_in_ctl.sel = SEL_ZERO;
        end else if (i_view_distance >= r_far) begin
            n_in_ctl.sel = SEL_LAST;
        end else begin
            n_in_ctl.sel = SEL_CALC;
        end
        n_in_man[LANE_D] = nrm_d.man;
        n_in_man[LANE_N] = nrm_n.man;
        n_in_man[LANE_F] = nrm_f.man;
        n_in_lg[LANE_D]  = LW'(nrm_d.pos);
        n_in_lg[LANE_N]  = LW'(nrm_n.pos);
        n_in_lg[LANE_F]  = LW'(nrm_f.pos);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_ctl <= '0;
        end else if (en) begin
            r_in_ctl <= n_in_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_in_man <= n_in_man;
            r_in_lg  <= n_in_lg;
        end
    end

    // row of squaring cells, one log fraction bit each
    t_ctl                         lc_ctl [0:LOG_FRAC_BITS];
    logic [LANES-1:0][DIST_W-1:0] lc_man [0:LOG_FRAC_BITS];
    logic [LANES-1:0][LW-1:0]     lc_lg  [0:LOG_FRAC_BITS];

    assign lc_ctl[0] = r_in_ctl;
    assign lc_man[0] = r_in_man;
    assign lc_lg[0]  = r_in_lg;

    for (genvar k = 0; k < LOG_FRAC_BITS; k++) begin : g_log
        lds_log_cell #(
            .LW (LW)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (lc_ctl[k]),
            .i_man   (lc_man[k]),
            .i_lg    (lc_lg[k]),
            .o_ctl   (lc_ctl[k+1]),
            .o_man   (lc_man[k+1]),
            .o_lg    (lc_lg[k+1])
        );
    end

    // log differences
    logic [LW-1:0] lg_d, lg_n, lg_f;
    logic [LW-1:0] n_num, n_den, r_num, r_den;
    t_ctl          n_dif_ctl, r_dif_ctl;

    assign lg_d = lc_lg[LOG_FRAC_BITS][LANE_D];
    assign lg_n = lc_lg[LOG_FRAC_BITS][LANE_N];
    assign lg_f = lc_lg[LOG_FRAC_BITS][LANE_F];

    always_comb begin
        n_num     = (lg_d > lg_n) ? (lg_d - lg_n) : '0;
        n_den     = (lg_f > lg_n) ? (lg_f - lg_n) : '0;
        n_dif_ctl = lc_ctl[LOG_FRAC_BITS];
        // flat log span gives slice zero
        if (n_dif_ctl.sel == SEL_CALC && n_den == '0) begin
            n_dif_ctl.sel = SEL_ZERO;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dif_ctl <= '0;
        end else if (en) begin
            r_dif_ctl <= n_dif_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_num <= n_num;
            r_den <= n_den;
        end
    end

    // dividend = num * count
    t_ctl          r_mul_ctl;
    logic [DW-1:0] r_dvd;
    logic [LW-1:0] r_mul_den;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mul_ctl <= '0;
        end else if (en) begin
            r_mul_ctl <= r_dif_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dvd     <= DW'(r_num) * DW'(cnt_c);
            r_mul_den <= r_den;
        end
    end

    // row of divider cells, one quotient bit each, msb first
    t_ctl          dv_ctl [0:QW];
    logic [DW-1:0] dv_rem [0:QW];
    logic [LW-1:0] dv_den [0:QW];
    logic [QW-1:0] dv_quo [0:QW];

    assign dv_ctl[0] = r_mul_ctl;
    assign dv_rem[0] = r_dvd;
    assign dv_den[0] = r_mul_den;
    assign dv_quo[0] = '0;

    for (genvar k = 0; k < QW; k++) begin : g_div
        lds_div_cell #(
            .LW   (LW),
            .QW   (QW),
            .DW   (DW),
            .STEP (QW - 1 - k)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (en),
            .i_ctl   (dv_ctl[k]),
            .i_rem   (dv_rem[k]),
            .i_den   (dv_den[k]),
            .i_quo   (dv_quo[k]),
            .o_ctl   (dv_ctl[k+1]),
            .o_rem   (dv_rem[k+1]),
            .o_den   (dv_den[k+1]),
            .o_quo   (dv_quo[k+1])
        );
    end

    // final selection and clamp
    t_ctl               fin_ctl;
    logic [QW-1:0]      fin_q;
    logic [QW-1:0]      fin_val;
    logic [31:0]        fin_ext;
    logic [SLICE_W-1:0] fin_slice;

    assign fin_ctl = dv_ctl[QW];
    assign fin_q   = dv_quo[QW];

    always_comb begin
        unique case (fin_ctl.sel)
            SEL_ZERO: fin_val = '0;
            SEL_LAST: fin_val = cnt_m1;
            SEL_CALC: fin_val = (fin_q > cnt_m1) ? cnt_m1 : fin_q;
            default:  fin_val = '0;
        endcase
    end

    assign fin_ext   = 32'(fin_val);
    assign fin_slice = fin_ext[SLICE_W-1:0];

    // output register with skid
    logic               r_out_vld;
    logic [SLICE_W-1:0] r_out_slice;
    logic [SLICE_W-1:0] r_skid_slice;
    logic               out_free;
    logic               fin_move;

    assign out_free = !r_out_vld || !i_out_stall;
    assign fin_move = fin_ctl.vld && en;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else if (out_free) begin
            if (r_skid_vld) begin
                r_out_vld  <= 1'b1;
                r_skid_vld <= 1'b0;
            end else begin
                r_out_vld  <= fin_move;
            end
        end else if (fin_move) begin
            r_skid_vld <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_free) begin
            r_out_slice <= r_skid_vld ? r_skid_slice : fin_slice;
        end else if (fin_move) begin
            r_skid_slice <= fin_slice;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_slice_index = r_out_slice;

    // skid holds an item only behind a held output item
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_vld |-> r_out_vld)
        else $error("skid item without an output item");

    // a skid item drains as soon as the output is taken, and nothing refills it
    a_skid_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_skid_vld && !i_out_stall) |=> !r_skid_vld)
        else $error("skid did not drain");

    // a forced-zero item landing in a free output shows slice zero
    a_zero_case: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (fin_move && fin_ctl.sel == SEL_ZERO && out_free && !r_skid_vld)
        |=> (o_out_valid && o_slice_index == '0))
        else $error("forced-zero item gave a nonzero slice");

endmodule

>>> design/lds_log_cell.sv
module lds_log_cell import lds_pkg::*; #(
    parameter int LW = POS_W + DEF_LOG_FRAC_BITS
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_en,
    input  t_ctl                          i_ctl,
    input  logic [LANES-1:0][DIST_W-1:0]  i_man,
    input  logic [LANES-1:0][LW-1:0]      i_lg,
    output t_ctl                          o_ctl,
    output logic [LANES-1:0][DIST_W-1:0]  o_man,
    output logic [LANES-1:0][LW-1:0]      o_lg
);

    t_ctl                         r_ctl;
    logic [LANES-1:0][DIST_W-1:0] r_man, n_man;
    logic [LANES-1:0][LW-1:0]     r_lg, n_lg;

    // one squaring per lane: a carry into bit 1 of the square is the next log bit
    always_comb begin
        logic [2*DIST_W-1:0] prod;
        prod  = '0;
        n_man = '0;
        n_lg  = '0;
        for (int l = 0; l < LANES; l++) begin
            prod = (2*DIST_W)'(i_man[l]) * (2*DIST_W)'(i_man[l]);
            if (prod[2*DIST_W-1]) begin
                n_man[l] = prod[2*DIST_W-1:DIST_W];
                n_lg[l]  = {i_lg[l][LW-2:0], 1'b1};
            end else begin
                n_man[l] = prod[2*DIST_W-2:DIST_W-1];
                n_lg[l]  = {i_lg[l][LW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_man <= n_man;
            r_lg  <= n_lg;
        end
    end

    assign o_ctl = r_ctl;
    assign o_man = r_man;
    assign o_lg  = r_lg;

endmodule

>>> design/lds_div_cell.sv
module lds_div_cell import lds_pkg::*; #(
    parameter int LW   = POS_W + DEF_LOG_FRAC_BITS,
    parameter int QW   = 9,
    parameter int DW   = LW + QW,
    parameter int STEP = 0
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_en,
    input  t_ctl          i_ctl,
    input  logic [DW-1:0] i_rem,
    input  logic [LW-1:0] i_den,
    input  logic [QW-1:0] i_quo,
    output t_ctl          o_ctl,
    output logic [DW-1:0] o_rem,
    output logic [LW-1:0] o_den,
    output logic [QW-1:0] o_quo
);

    t_ctl          r_ctl;
    logic [DW-1:0] r_rem, n_rem;
    logic [LW-1:0] r_den;
    logic [QW-1:0] r_quo, n_quo;
    logic [DW-1:0] trial;
    logic          ge;

    // restoring step for quotient bit STEP
    assign trial = DW'(i_den) << STEP;
    assign ge    = (i_rem >= trial);
    assign n_rem = ge ? (i_rem - trial) : i_rem;
    assign n_quo = {i_quo[QW-2:0], ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctl <= '0;
        end else if (i_en) begin
            r_ctl <= i_ctl;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem <= n_rem;
            r_den <= i_den;
            r_quo <= n_quo;
        end
    end

    assign o_ctl = r_ctl;
    assign o_rem = r_rem;
    assign o_den = r_den;
    assign o_quo = r_quo;

endmodule

>>> verif/testbench.sv
// tracks slices still in flight and compares each result against the oldest
class slice_scoreboard;
    logic [7:0]  pending_slices[$];
    logic [31:0] pending_dist[$];
    int          errors;
    int          checked;

    function void flag(string msg);
        errors++;
        if (errors <= 10) begin
            $display("mismatch: %s", msg);
        end
    endfunction

    function void note(logic [31:0] view_dist, logic [7:0] slice);
        pending_dist.push_back(view_dist);
        pending_slices.push_back(slice);
    endfunction

    function void check(logic [7:0] got);
        logic [7:0]  want;
        logic [31:0] view_dist;
        if (pending_slices.size() == 0) begin
            flag($sformatf("slice %0d arrived with no item in flight", got));
            return;
        end
        want      = pending_slices.pop_front();
        view_dist = pending_dist.pop_front();
        checked++;
        if (got !== want) begin
            flag($sformatf("distance %h: slice expected %0d, got %0d", view_dist, want, got));
        end
    endfunction

    function int waiting();
        return pending_slices.size();
    endfunction
endclass

module testbench;
    import lds_pkg::*;

    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 40;
    localparam int HOLD_CYCLES = 150;

    logic                  i_clk           = 1'b0;
    logic                  i_rst_n         = 1'b0;
    logic                  i_cfg_we        = 1'b0;
    logic [CFG_ADDR_W-1:0] i_cfg_addr      = CFG_PROJ_SET;
    logic [CFG_DATA_W-1:0] i_cfg_data      = '0;
    logic                  i_in_valid      = 1'b0;
    logic                  o_in_stall;
    logic [DIST_W-1:0]     i_view_distance = '0;
    logic                  o_out_valid;
    logic                  i_out_stall     = 1'b0;
    logic [SLICE_W-1:0]    o_slice_index;

    // shadow of the block's registers
    logic                 proj_on   = 1'b0;
    logic [DIST_W-1:0]    near_q    = RST_NEAR;
    logic [DIST_W-1:0]    far_q     = RST_FAR;
    logic [CNT_REG_W-1:0] count_reg = RST_COUNT;

    slice_scoreboard sb;
    int cycles       = 0;
    int gap_pct      = 0;
    int stall_pct    = 0;
    int burst_left   = 0;
    int hold_left    = 0;
    int settings_cnt = 0;
    bit hold_go      = 1'b0;

    log_depth_slice_select dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_addr     (i_cfg_addr),
        .i_cfg_data     (i_cfg_data),
        .i_in_valid     (i_in_valid),
        .o_in_stall     (o_in_stall),
        .i_view_distance(i_view_distance),
        .o_out_valid    (o_out_valid),
        .i_out_stall    (i_out_stall),
        .o_slice_index  (o_slice_index)
    );

    always #5 i_clk = ~i_clk;

    // log2 with the integer part from the leading one, fraction by repeated squaring
    function automatic logic [63:0] log2_fixed(input logic [31:0] x);
        int          pos;
        logic [63:0] m;
        logic [63:0] acc;
        pos = 0;
        for (int b = 0; b < 32; b++) begin
            if (x[b]) pos = b;
        end
        m   = ({32'd0, x} << (31 - pos)) & 64'hFFFF_FFFF;
        acc = 64'(pos);
        repeat (DEF_LOG_FRAC_BITS) begin
            m   = (m * m) >> 31;
            acc = acc << 1;
            if (m >= 64'h1_0000_0000) begin
                acc[0] = 1'b1;
                m      = m >> 1;
            end
        end
        return acc;
    endfunction

    function automatic logic [7:0] slice_of_distance(input logic [31:0] d);
        logic [63:0] cnt;
        logic [63:0] ln;
        logic [63:0] ld;
        logic [63:0] lf;
        logic [63:0] num;
        logic [63:0] den;
        logic [63:0] q;
        cnt = count_reg;
        if (cnt < 1) cnt = 1;
        if (cnt > DEF_MAX_SLICES) cnt = DEF_MAX_SLICES;
        if (!proj_on || near_q == 0 || far_q <= near_q || d <= near_q) begin
            q = 0;
        end else if (d >= far_q) begin
            q = cnt - 1;
        end else begin
            ln  = log2_fixed(near_q);
            ld  = log2_fixed(d);
            lf  = log2_fixed(far_q);
            num = (ld > ln) ? ld - ln : 0;
            den = (lf > ln) ? lf - ln : 0;
            // flat log span or a zero log difference: either one vanishing gives slice zero, no divide
            if (den == 0 || num == 0) q = 0;
            else q = (num * cnt) / den;
            if (q > cnt - 1) q = cnt - 1;
        end
        return q[7:0];
    endfunction

    function automatic logic [31:0] pick_distance();
        logic [31:0] d;
        case ($urandom_range(5))
            0: d = $urandom();
            1, 2: begin
                if (far_q > near_q) d = near_q + $urandom_range(far_q - near_q);
                else d = $urandom();
            end
            3: d = near_q + $urandom_range(4) - 2;
            4: d = far_q + $urandom_range(4) - 2;
            default: d = $urandom() >> $urandom_range(31);
        endcase
        return d;
    endfunction

    // output side: checks accepted slices and plays the stall pattern
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            sb.check(o_slice_index);
        end
        if (hold_go) begin
            hold_left = HOLD_CYCLES;
            hold_go   = 1'b0;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else if (burst_left > 0) begin
            burst_left--;
            i_out_stall <= 1'b1;
        end else if (stall_pct != 0 && $urandom_range(99) < stall_pct) begin
            burst_left = $urandom_range(4);
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= 1'b0;
        end
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycles);
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic send_distance(input logic [31:0] d);
        int gap;
        i_in_valid      <= 1'b1;
        i_view_distance <= d;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        sb.note(d, slice_of_distance(d));
        if (gap_pct != 0 && $urandom_range(99) < gap_pct) begin
            gap = $urandom_range(5, 1);
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    // stop offering items and let every slice in flight come out
    task automatic settle();
        i_in_valid <= 1'b0;
        while (sb.waiting() != 0) @(posedge i_clk);
        repeat (DRAIN_WAIT) @(posedge i_clk);
    endtask

    task automatic program_planes(input logic proj, input logic [31:0] nr,
                                  input logic [31:0] fr, input logic [8:0] cnt);
        settle();
        i_cfg_we   <= 1'b1;
        i_cfg_addr <= CFG_PROJ_SET;
        i_cfg_data <= {31'd0, proj};
        @(posedge i_clk);
        i_cfg_addr <= CFG_NEAR;
        i_cfg_data <= nr;
        @(posedge i_clk);
        i_cfg_addr <= CFG_FAR;
        i_cfg_data <= fr;
        @(posedge i_clk);
        i_cfg_addr <= CFG_COUNT;
        i_cfg_data <= {23'd0, cnt};
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        proj_on   = proj;
        near_q    = nr;
        far_q     = fr;
        count_reg = cnt;
        settings_cnt++;
    endtask

    task automatic random_planes(input bit allow_bad);
        logic [31:0] nr;
        logic [31:0] fr;
        logic [31:0] span;
        nr   = $urandom() >> $urandom_range(31);
        span = $urandom() >> $urandom_range(31);
        if (nr == 0) nr = 1;
        fr = nr + span;
        if (fr <= nr) fr = 32'hFFFF_FFFF;
        if (allow_bad) begin
            case ($urandom_range(5))
                0: nr = 0;
                1: fr = nr - $urandom_range(1000);
                2: fr = nr;
                default: ;
            endcase
        end
        program_planes($urandom_range(9) != 0, nr, fr, 9'($urandom_range(511)));
    endtask

    task automatic random_items(input int n);
        repeat (n) send_distance(pick_distance());
    endtask

    initial begin
        sb = new();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: projection still off after reset
        gap_pct   = 30;
        stall_pct = 30;
        send_distance(32'h0);
        send_distance(32'hFFFF_FFFF);
        send_distance(32'h1000_0000);

        program_planes(1'b1, RST_NEAR, RST_FAR, RST_COUNT);
        send_distance(32'h0);
        send_distance(RST_NEAR);
        send_distance(RST_NEAR + 1);
        send_distance(RST_FAR - 1);
        send_distance(RST_FAR);
        send_distance(32'hFFFF_FFFF);
        send_distance(32'h0010_0000);
        send_distance(32'h0100_0000);

        // near plane at zero
        program_planes(1'b1, 32'h0, 32'd100000, 9'd16);
        send_distance(32'h5);
        send_distance(32'h0020_0000);

        // far below near, then far equal to near
        program_planes(1'b1, 32'h0020_0000, 32'h0010_0000, 9'd16);
        send_distance(32'h0030_0000);
        send_distance(32'h0015_0000);
        program_planes(1'b1, 32'h0008_0000, 32'h0008_0000, 9'd16);
        send_distance(32'h0009_0000);

        // planes so close that their logs truncate to the same value
        program_planes(1'b1, 32'h1000_0000, 32'h1000_0002, 9'd256);
        send_distance(32'h1000_0001);

        // zero count, oversized count, widest count
        program_planes(1'b1, 32'h1, 32'hFFFF_FFFF, 9'd0);
        send_distance(32'h0000_8000);
        send_distance(32'hFFFF_FFFF);
        program_planes(1'b1, 32'h1, 32'hFFFF_FFFF, 9'h1FF);
        send_distance(32'h8000_0000);
        send_distance(32'hFFFF_FFFE);
        send_distance(32'hFFFF_FFFF);
        program_planes(1'b1, 32'h1, 32'hFFFF_FFFF, 9'd256);
        send_distance(32'h2);
        send_distance(32'h7FFF_FFFF);

        // random part
        program_planes(1'b1, RST_NEAR, RST_FAR, RST_COUNT);
        random_items(120);

        gap_pct   = 0;
        stall_pct = 0;
        program_planes(1'b1, 32'h1, 32'hFFFF_FFFF, 9'd256);
        random_items(120);

        // long output hold-off while items keep coming, so the input backs up
        gap_pct   = 20;
        stall_pct = 20;
        random_planes(1'b0);
        hold_go = 1'b1;
        random_items(120);

        program_planes(1'b0, $urandom(), $urandom(), 9'($urandom_range(511)));
        random_items(40);

        gap_pct   = 40;
        stall_pct = 40;
        random_planes(1'b0);
        program_planes(1'b1, near_q, far_q, 9'd1);
        random_items(80);

        repeat (4) begin
            gap_pct   = $urandom_range(50);
            stall_pct = $urandom_range(50);
            random_planes(1'b1);
            random_items(60);
        end

        // closing stretch without idling
        gap_pct   = 0;
        stall_pct = 0;
        random_planes(1'b0);
        random_items(120);

        settle();
        if (sb.waiting() != 0) begin
            sb.flag($sformatf("%0d slices never arrived", sb.waiting()));
        end
        $display("checked %0d slice results under %0d register settings, %0d errors",
                 sb.checked, settings_cnt, sb.errors);
        $display("covered projection off, degenerate planes, flat log span, count limits, long hold-off");
        if (sb.errors == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end
endmodule
